FILE: rtl/mcgd_pkg.sv
// Shared codes, defaults and types for the mouse click gesture decoder.
`timescale 1ns / 1ps

package mcgd_pkg;

	// Field widths
	localparam int TIMEOUT_W   = 16;
	localparam int OFFSET_W    = 8;
	localparam int GESTURE_W   = 3;
	localparam int S_DATA_W    = 32;
	localparam int M_DATA_W    = 8;

	// Reset values
	localparam int DEFAULT_COUNT_WIDTH = 16;
	localparam logic [TIMEOUT_W-1:0] DEFAULT_TIMEOUT = 16'd300;

	typedef logic [GESTURE_W-1:0] gesture_t;
	typedef logic [1:0]           pend_t;
	typedef logic [OFFSET_W-1:0]  offset_t;

	// Pending click codes (code 3 unused, treated as none)
	localparam pend_t PEND_LEFT  = 2'd0;
	localparam pend_t PEND_RIGHT = 2'd1;
	localparam pend_t PEND_NONE  = 2'd2;

	// Item kinds carried on tuser
	localparam logic FUNC_PACKET = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	// Gesture codes
	localparam gesture_t G_DBL_LEFT   = 3'd0;
	localparam gesture_t G_DBL_RIGHT  = 3'd1;
	localparam gesture_t G_LEFT       = 3'd2;
	localparam gesture_t G_RIGHT      = 3'd3;
	localparam gesture_t G_MIDDLE     = 3'd4;
	localparam gesture_t G_WHEEL_DOWN = 3'd5;
	localparam gesture_t G_WHEEL_UP   = 3'd6;
	localparam gesture_t G_QUIT       = 3'd7;

	// One decoded input word
	typedef struct packed {
		offset_t wheel_z;
		offset_t move_y;
		offset_t move_x;
		logic    middle_pressed;
		logic    right_pressed;
		logic    left_pressed;
	} packet_t;

endpackage

FILE: rtl/mouse_click_gesture_decoder.sv
// Top level: classifies mouse packets and millisecond ticks into gesture words.
`timescale 1ns / 1ps

// An accepted word passes through the input register and then the result register, which
// drives its gesture on m_tvalid. Throughput: one input word per cycle while the result
// slot is free or draining; the state update between the two registers is combinational.
// Reset (arst_n low): timeout back to 300 ms, no click pending, counter zero, halt cleared,
// both pipeline registers emptied. After quit the block drops all words until reset.
module mouse_click_gesture_decoder #(
	parameter int COUNT_WIDTH = mcgd_pkg::DEFAULT_COUNT_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mcgd_pkg::TIMEOUT_W-1:0]    cfg_wdata,   // click_timeout_ms
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [0] left_pressed, [1] right_pressed, [2] middle_pressed, [10:3] move_x,
	// [18:11] move_y, [26:19] wheel_z, [31:27] zero
	input  logic [mcgd_pkg::S_DATA_W-1:0]     s_tdata,
	input  logic                              s_tuser,     // [0] func
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mcgd_pkg::M_DATA_W-1:0]     m_tdata      // [2:0] gesture, [7:3] zero
);
	import mcgd_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [TIMEOUT_W-1:0]   timeout_q;
	pend_t                  pend_q;
	logic [COUNT_WIDTH-1:0] elapsed_q;
	logic                   halted_q;

	logic                   valid_s1;
	logic                   func_s1;
	packet_t                pkt_s1;

	logic                   out_valid_q;
	gesture_t               gesture_q;

	logic                   advance;
	pend_t                  pend_d;
	logic [COUNT_WIDTH-1:0] elapsed_d;
	logic                   halted_d;
	logic                   res_valid;
	gesture_t               res_gesture;
	logic [COUNT_WIDTH-1:0] elapsed_inc;
	logic                   pending;
	logic                   motionless;
	logic                   press;
	pend_t                  press_btn;

	// Handshakes: stage 1 moves on when the result slot is free or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_DATA_W-GESTURE_W){1'b0}}, gesture_q};

	// Timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= DEFAULT_TIMEOUT;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			pkt_s1  <= packet_t'(s_tdata[$bits(packet_t)-1:0]);
		end
	end

	// Gesture classification and next state
	assign pending     = (pend_q == PEND_LEFT) || (pend_q == PEND_RIGHT);
	assign elapsed_inc = (elapsed_q != COUNT_MAX) ? elapsed_q + 1'b1 : elapsed_q;
	assign motionless  = (pkt_s1.move_x == '0) && (pkt_s1.move_y == '0)
	                     && (pkt_s1.wheel_z == '0);
	assign press       = motionless && (pkt_s1.left_pressed || pkt_s1.right_pressed);
	assign press_btn   = pkt_s1.left_pressed ? PEND_LEFT : PEND_RIGHT;

	always_comb begin
		pend_d      = pend_q;
		elapsed_d   = elapsed_q;
		halted_d    = halted_q;
		res_valid   = 1'b0;
		res_gesture = G_QUIT;
		priority if (halted_q) begin
			// dropped
		end else if (func_s1 == FUNC_TICK) begin
			if (pending) begin
				elapsed_d = elapsed_inc;
				if (CMP_W'(elapsed_inc) >= CMP_W'(timeout_q)) begin
					res_valid   = 1'b1;
					res_gesture = (pend_q == PEND_LEFT) ? G_LEFT : G_RIGHT;
					pend_d      = PEND_NONE;
				end
			end
		end else if (press) begin
			if (!pending) begin
				pend_d    = press_btn;
				elapsed_d = '0;
			end else if (pend_q != press_btn) begin
				pend_d      = PEND_NONE;
				halted_d    = 1'b1;
				res_valid   = 1'b1;
				res_gesture = G_QUIT;
			end else begin
				pend_d      = PEND_NONE;
				res_valid   = 1'b1;
				res_gesture = (press_btn == PEND_LEFT) ? G_DBL_LEFT : G_DBL_RIGHT;
			end
		end else if (motionless) begin
			if (pkt_s1.middle_pressed) begin
				res_valid   = 1'b1;
				res_gesture = G_MIDDLE;
			end
		end else if (pkt_s1.wheel_z != '0) begin
			res_valid   = 1'b1;
			res_gesture = pkt_s1.wheel_z[OFFSET_W-1] ? G_WHEEL_UP : G_WHEEL_DOWN;
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= PEND_NONE;
			elapsed_q <= '0;
			halted_q  <= 1'b0;
		end else if (advance) begin
			pend_q    <= pend_d;
			elapsed_q <= elapsed_d;
			halted_q  <= halted_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			gesture_q <= res_gesture;
		end
	end

	// Checks
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared without reset");

	a_halt_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> (pend_q == PEND_NONE))
		else $error("click pending while halted");

	a_quit_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (gesture_q == G_QUIT)) |-> halted_q)
		else $error("quit word without halt");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a blocked result");

endmodule
